### rtl/ahpp_pkg.sv
// ----------------------------------------------------------------------------
// ahpp_pkg
// Shared types, constants and the hex digit decode for the packet parser.
// ----------------------------------------------------------------------------
package ahpp_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 32;
    localparam int CHAR_W            = 8;
    localparam int COUNT_OUT_W       = 6;
    localparam int APB_AW            = 3;
    localparam int APB_DW            = 32;

    localparam logic [CHAR_W-1:0] CH_WRITE      = 8'h57;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF         = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR         = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    // 'A' minus ten
    localparam logic [CHAR_W-1:0] HEX_ALPHA_OFS = 8'h37;
    localparam logic [CHAR_W-1:0] START_CHAR_RST = 8'h53;
    localparam logic [CHAR_W-1:0] END_CHAR_RST   = 8'h50;

    typedef enum logic [0:0] {
        REG_START_CHAR = 1'b0,
        REG_END_CHAR   = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RW,
        ST_ADDR,
        ST_CMD,
        ST_DATA,
        ST_FAULT,
        ST_FAULT_OUT,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic rw_load;
        logic addr_clr;
        logic addr_hi;
        logic addr_lo;
        logic cmd_hi;
        logic cmd_lo;
        logic data_hi;
        logic data_lo;
        logic emit_clr;
        logic emit_step;
        logic out_load;
        logic fault_load;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic is_start;
        logic is_end;
        logic is_write;
        logic high_next;
        logic emit_empty;
        logic emit_last;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic                   status;
        logic [CHAR_W-1:0]      target_address;
        logic [CHAR_W-1:0]      command_code;
        logic [COUNT_OUT_W-1:0] byte_count;
        logic [CHAR_W-1:0]      data_byte;
        logic                   overflowed;
        logic                   last;
    } t_result;

    function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        if (c > CH_NINE) begin
            v = c - HEX_ALPHA_OFS;
        end else begin
            v = c - CH_ZERO;
        end
        return v[3:0];
    endfunction

endpackage

### rtl/ahpp_if.sv
// ----------------------------------------------------------------------------
// ahpp_if
// Valid/ready channels for received characters and parsed results.
// ----------------------------------------------------------------------------
interface ahpp_rx_if;
    import ahpp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

interface ahpp_res_if;
    import ahpp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   status;
    logic [CHAR_W-1:0]      target_address;
    logic [CHAR_W-1:0]      command_code;
    logic [COUNT_OUT_W-1:0] byte_count;
    logic [CHAR_W-1:0]      data_byte;
    logic                   overflowed;
    logic                   last;

    modport source (
        output valid, output status, output target_address, output command_code,
        output byte_count, output data_byte, output overflowed, output last,
        input ready
    );
    modport sink (
        input valid, input status, input target_address, input command_code,
        input byte_count, input data_byte, input overflowed, input last,
        output ready
    );
endinterface

### rtl/ahpp_ctrl.sv
// ----------------------------------------------------------------------------
// ahpp_ctrl
// Parser state machine: sequences decode, buffering and result emission.
// ----------------------------------------------------------------------------
module ahpp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    input  ahpp_pkg::t_dp_stat i_stat,
    output logic               o_rx_ready,
    output ahpp_pkg::t_dp_cmd  o_cmd
);
    import ahpp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   act;

    assign act = i_rx_valid && o_rx_ready && !i_stat.skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (act) begin
                    n_state = i_stat.is_start ? ST_RW : ST_FAULT_OUT;
                end
            end
            ST_RW: begin
                if (act) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                if (act && !i_stat.high_next) begin
                    n_state = ST_CMD;
                end
            end
            ST_CMD: begin
                if (act && !i_stat.high_next) begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                if (act && i_stat.is_end) begin
                    if (!i_stat.is_write) begin
                        n_state = ST_IDLE;
                    end else if (i_stat.emit_empty) begin
                        n_state = ST_EMIT_OUT;
                    end else begin
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_FAULT: begin
                n_state = ST_FAULT;
            end
            ST_FAULT_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_FAULT;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_rx_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_rx_ready     = 1'b1;
                o_cmd.addr_clr = act && i_stat.is_start;
            end
            ST_RW: begin
                o_rx_ready    = 1'b1;
                o_cmd.rw_load = act;
            end
            ST_ADDR: begin
                o_rx_ready    = 1'b1;
                o_cmd.addr_hi = act && i_stat.high_next;
                o_cmd.addr_lo = act && !i_stat.high_next;
            end
            ST_CMD: begin
                o_rx_ready   = 1'b1;
                o_cmd.cmd_hi = act && i_stat.high_next;
                o_cmd.cmd_lo = act && !i_stat.high_next;
            end
            ST_DATA: begin
                o_rx_ready     = 1'b1;
                o_cmd.emit_clr = act && i_stat.is_end;
                o_cmd.data_hi  = act && !i_stat.is_end && i_stat.high_next;
                o_cmd.data_lo  = act && !i_stat.is_end && !i_stat.high_next;
            end
            ST_FAULT: begin
                o_rx_ready = 1'b1;
            end
            ST_FAULT_OUT: begin
                o_cmd.fault_load = i_stat.out_free;
            end
            ST_EMIT_RD: begin
                o_rx_ready = 1'b0;
            end
            ST_EMIT_OUT: begin
                o_cmd.out_load  = i_stat.out_free;
                o_cmd.emit_step = i_stat.out_free && !i_stat.emit_last;
            end
            default: begin
                o_rx_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/ahpp_dp.sv
// ----------------------------------------------------------------------------
// ahpp_dp
// Datapath: hex decode, header registers, payload buffer and result register.
// ----------------------------------------------------------------------------
module ahpp_dp #(
    parameter int PAYLOAD_DEPTH = ahpp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ahpp_pkg::CHAR_W-1:0]   i_rx_char,
    input  logic [ahpp_pkg::CHAR_W-1:0]   i_start_char,
    input  logic [ahpp_pkg::CHAR_W-1:0]   i_end_char,
    input  logic                          i_out_ready,
    input  ahpp_pkg::t_dp_cmd             i_cmd,
    output ahpp_pkg::t_dp_stat            o_stat,
    output logic                          o_out_valid,
    output ahpp_pkg::t_result             o_result
);
    import ahpp_pkg::*;

    localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
    localparam int IDX_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PAYLOAD_DEPTH);

    logic [CHAR_W-1:0] mem [PAYLOAD_DEPTH];

    logic              r_rw_write;
    logic [CHAR_W-1:0] r_addr;
    logic [CHAR_W-1:0] r_cmd;
    logic              r_high_next;
    logic [3:0]        r_pend;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovf;
    logic [IDX_W-1:0]  r_idx;
    logic [CHAR_W-1:0] r_rd_data;
    logic              r_out_valid;
    t_result           r_result;

    logic [3:0]        nib;
    logic              buf_full;
    logic              out_free;
    logic [CNT_W-1:0]  idx_next;

    assign nib      = hex_nibble(i_rx_char);
    assign buf_full = (r_cnt >= DEPTH_C);
    assign out_free = !r_out_valid || i_out_ready;
    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);

    assign o_stat.skip       = (i_rx_char == CH_SPACE) || (i_rx_char == CH_LF)
                               || (i_rx_char == CH_CR);
    assign o_stat.is_start   = (i_rx_char == i_start_char);
    assign o_stat.is_end     = (i_rx_char == i_end_char);
    assign o_stat.is_write   = r_rw_write;
    assign o_stat.high_next  = r_high_next;
    assign o_stat.emit_empty = (r_cnt == '0);
    assign o_stat.emit_last  = (r_cnt == '0) || (idx_next == r_cnt);
    assign o_stat.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.data_lo && !buf_full) begin
            mem[r_cnt[IDX_W-1:0]] <= {r_pend, nib};
        end
        r_rd_data <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rw_write  <= 1'b0;
            r_addr      <= '0;
            r_cmd       <= '0;
            r_high_next <= 1'b1;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.rw_load) begin
                r_rw_write  <= (i_rx_char == CH_WRITE);
                r_high_next <= 1'b1;
            end
            if (i_cmd.addr_clr) begin
                r_addr <= '0;
            end
            if (i_cmd.addr_hi) begin
                r_addr      <= {nib, 4'h0};
                r_high_next <= 1'b0;
            end
            if (i_cmd.addr_lo) begin
                r_addr      <= {r_addr[7:4], r_addr[3:0] | nib};
                r_cmd       <= '0;
                r_high_next <= 1'b1;
            end
            if (i_cmd.cmd_hi) begin
                r_cmd       <= {nib, 4'h0};
                r_high_next <= 1'b0;
            end
            if (i_cmd.cmd_lo) begin
                r_cmd       <= {r_cmd[7:4], r_cmd[3:0] | nib};
                r_high_next <= 1'b1;
                r_cnt       <= '0;
                r_ovf       <= 1'b0;
            end
            if (i_cmd.data_hi) begin
                r_high_next <= 1'b0;
            end
            if (i_cmd.data_lo) begin
                r_high_next <= 1'b1;
                if (buf_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (i_cmd.emit_clr) begin
                r_idx <= '0;
            end else if (i_cmd.emit_step) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.data_hi) begin
            r_pend <= nib;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load || i_cmd.fault_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fault_load) begin
            r_result.status         <= 1'b1;
            r_result.target_address <= '0;
            r_result.command_code   <= '0;
            r_result.byte_count     <= '0;
            r_result.data_byte      <= '0;
            r_result.overflowed     <= 1'b0;
            r_result.last           <= 1'b1;
        end else if (i_cmd.out_load) begin
            r_result.status         <= 1'b0;
            r_result.target_address <= r_addr;
            r_result.command_code   <= r_cmd;
            r_result.byte_count     <= COUNT_OUT_W'(r_cnt);
            r_result.data_byte      <= (r_cnt == '0) ? '0 : r_rd_data;
            r_result.overflowed     <= r_ovf;
            r_result.last           <= o_stat.emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

### rtl/ascii_hex_packet_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_hex_packet_parser_core
// Parses start/rw/address/command/hex-data/end packets from a character stream.
// ----------------------------------------------------------------------------
// Takes one received character per cycle while parsing; spaces, LF and CR are
// dropped. On the end character of a write packet the character input stalls
// while one result per buffered byte is produced; each result passes through
// the payload buffer read register, then the result register, and is held by
// backpressure on the result channel; an empty write packet gives one result.
// A bad opening character gives a single fault result and the parser then
// discards everything until reset. start_char sits at byte address 0 and
// end_char at 4 on the APB port; write them only while the parser is idle.
// ----------------------------------------------------------------------------
module ascii_hex_packet_parser_core #(
    parameter int PAYLOAD_DEPTH = ahpp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ahpp_pkg::APB_AW-1:0]   paddr,
    input  logic [ahpp_pkg::APB_DW-1:0]   pwdata,
    output logic [ahpp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    ahpp_rx_if.sink                       i_rx,
    ahpp_res_if.source                    o_res
);
    import ahpp_pkg::*;

    logic [CHAR_W-1:0] r_start_char;
    logic [CHAR_W-1:0] r_end_char;
    t_reg_idx          reg_idx;
    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    t_result           result;
    logic              out_valid;
    logic              rx_ready;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= START_CHAR_RST;
            r_end_char   <= END_CHAR_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_START_CHAR: r_start_char <= pwdata[CHAR_W-1:0];
                REG_END_CHAR:   r_end_char   <= pwdata[CHAR_W-1:0];
                default:        r_start_char <= r_start_char;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_CHAR: prdata = APB_DW'(r_start_char);
            REG_END_CHAR:   prdata = APB_DW'(r_end_char);
            default:        prdata = '0;
        endcase
    end

    ahpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx.valid),
        .i_stat     (dp_stat),
        .o_rx_ready (rx_ready),
        .o_cmd      (dp_cmd)
    );

    ahpp_dp #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_char    (i_rx.rx_char),
        .i_start_char (r_start_char),
        .i_end_char   (r_end_char),
        .i_out_ready  (o_res.ready),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_out_valid  (out_valid),
        .o_result     (result)
    );

    assign i_rx.ready           = rx_ready;
    assign o_res.valid          = out_valid;
    assign o_res.status         = result.status;
    assign o_res.target_address = result.target_address;
    assign o_res.command_code   = result.command_code;
    assign o_res.byte_count     = result.byte_count;
    assign o_res.data_byte      = result.data_byte;
    assign o_res.overflowed     = result.overflowed;
    assign o_res.last           = result.last;

endmodule

### verif/ahpp_packet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahpp_packet_checker
// Scoreboard for the ASCII hex packet parser. It watches the character and
// result channels and the APB register writes, runs its own copy of the
// parser, and compares each result transfer field by field with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module ahpp_packet_checker #(
    parameter int PAYLOAD_DEPTH = ahpp_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ahpp_pkg::APB_AW-1:0] paddr,
    input  logic [ahpp_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    ahpp_rx_if                          i_rx,
    ahpp_res_if                         i_res,
    output int                          o_mismatches,
    output int                          o_outstanding
);
    import ahpp_pkg::*;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;

    logic [CHAR_W-1:0] open_ch;
    logic [CHAR_W-1:0] close_ch;
    t_state            phase;
    logic [CHAR_W-1:0] rw_seen;
    logic [CHAR_W-1:0] addr_acc;
    logic [CHAR_W-1:0] cmd_acc;
    logic [CHAR_W-1:0] hi_part;
    logic              want_high;
    logic              dropped;
    int unsigned       held;
    logic [CHAR_W-1:0] payload [PAYLOAD_DEPTH];
    t_result           results_due [$];
    int                mismatch_count = 0;

    function automatic logic [3:0] nibble_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = (c > CH_NINE) ? c - CH_UPPER_A + 8'd10 : c - CH_ZERO;
        return v[3:0];
    endfunction

    task automatic parse_char(input logic [CHAR_W-1:0] c);
        logic [3:0] nib;
        t_result    r;
        if (c == CH_SPACE || c == CH_LF || c == CH_CR) begin
            return;
        end
        nib = nibble_of(c);
        r   = '0;
        case (phase)
            ST_IDLE: begin
                if (c == open_ch) begin
                    addr_acc = '0;
                    phase    = ST_RW;
                end else begin
                    r.status = 1'b1;
                    r.last   = 1'b1;
                    results_due.push_back(r);
                    phase = ST_FAULT;
                end
            end
            ST_RW: begin
                rw_seen   = c;
                want_high = 1'b1;
                phase     = ST_ADDR;
            end
            ST_ADDR: begin
                if (want_high) begin
                    addr_acc  = {nib, 4'h0};
                    want_high = 1'b0;
                end else begin
                    addr_acc[3:0] = nib;
                    want_high     = 1'b1;
                    cmd_acc       = '0;
                    phase         = ST_CMD;
                end
            end
            ST_CMD: begin
                if (want_high) begin
                    cmd_acc   = {nib, 4'h0};
                    want_high = 1'b0;
                end else begin
                    cmd_acc[3:0] = nib;
                    want_high    = 1'b1;
                    held         = 0;
                    dropped      = 1'b0;
                    phase        = ST_DATA;
                end
            end
            ST_DATA: begin
                if (c == close_ch) begin
                    if (rw_seen == CH_WRITE) begin
                        r.target_address = addr_acc;
                        r.command_code   = cmd_acc;
                        r.overflowed     = dropped;
                        if (held == 0) begin
                            r.last = 1'b1;
                            results_due.push_back(r);
                        end else begin
                            for (int i = 0; i < held; i++) begin
                                r.byte_count = COUNT_OUT_W'(held);
                                r.data_byte  = payload[i];
                                r.last       = (i == held - 1);
                                results_due.push_back(r);
                            end
                        end
                    end
                    phase = ST_IDLE;
                end else if (want_high) begin
                    hi_part   = {nib, 4'h0};
                    want_high = 1'b0;
                end else begin
                    want_high = 1'b1;
                    if (held < PAYLOAD_DEPTH) begin
                        payload[held] = hi_part | {4'h0, nib};
                        held++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input t_result seen);
        t_result want;
        if (results_due.size() == 0) begin
            note_mismatch("unexpected result, address", seen.target_address, 0);
            return;
        end
        want = results_due.pop_front();
        if (seen.status != want.status) begin
            note_mismatch("status", seen.status, want.status);
        end
        if (seen.target_address != want.target_address) begin
            note_mismatch("target_address", seen.target_address, want.target_address);
        end
        if (seen.command_code != want.command_code) begin
            note_mismatch("command_code", seen.command_code, want.command_code);
        end
        if (seen.byte_count != want.byte_count) begin
            note_mismatch("byte_count", seen.byte_count, want.byte_count);
        end
        if (seen.data_byte != want.data_byte) begin
            note_mismatch("data_byte", seen.data_byte, want.data_byte);
        end
        if (seen.overflowed != want.overflowed) begin
            note_mismatch("overflowed", seen.overflowed, want.overflowed);
        end
        if (seen.last != want.last) begin
            note_mismatch("last", seen.last, want.last);
        end
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        if (!i_rst_n) begin
            open_ch   = START_CHAR_RST;
            close_ch  = END_CHAR_RST;
            phase     = ST_IDLE;
            rw_seen   = '0;
            addr_acc  = '0;
            cmd_acc   = '0;
            hi_part   = '0;
            want_high = 1'b1;
            held      = 0;
            dropped   = 1'b0;
            results_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr >> 2))
                    REG_START_CHAR: open_ch  = pwdata[CHAR_W-1:0];
                    REG_END_CHAR:   close_ch = pwdata[CHAR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_rx.valid && i_rx.ready) begin
                parse_char(i_rx.rx_char);
            end
            if (i_res.valid && i_res.ready) begin
                seen.status         = i_res.status;
                seen.target_address = i_res.target_address;
                seen.command_code   = i_res.command_code;
                seen.byte_count     = i_res.byte_count;
                seen.data_byte      = i_res.data_byte;
                seen.overflowed     = i_res.overflowed;
                seen.last           = i_res.last;
                check_result(seen);
            end
        end
        o_mismatches  = mismatch_count;
        o_outstanding = results_due.size();
    end

endmodule

### verif/tb_ascii_hex_packet_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_hex_packet_parser_core
// Stimulus and verdict for the ASCII hex packet parser. A few hand-written
// packets come first, then random packets (mostly well formed, some with bad
// read/write characters, stray bytes in the hex fields, odd digit counts and
// buffer overruns) under changing start/end characters, with random gaps on
// the character side and random stalls on the result side. The run closes by
// forcing the framing fault. Checking is done by ahpp_packet_checker.
// ----------------------------------------------------------------------------
module tb_ascii_hex_packet_parser_core;
    import ahpp_pkg::*;

    localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
    localparam int                WRITE_SETTLE = 24;
    localparam int                DRAIN_LIMIT  = 100000;
    localparam int                ITEM_TARGET  = 380;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                outstanding;

    logic [CHAR_W-1:0] open_ch;
    logic [CHAR_W-1:0] close_ch;
    int                gap_max;
    int                stall_max;
    int                items_sent;

    ahpp_rx_if  rx_ch ();
    ahpp_res_if res_ch ();

    ascii_hex_packet_parser_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    ahpp_packet_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .i_rx          (rx_ch),
        .i_res         (res_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic is_skip(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char();
        logic [CHAR_W-1:0] v;
        v = CHAR_W'($urandom_range(0, 15));
        return (v < 10) ? CH_ZERO + v : CH_UPPER_A + v - 8'd10;
    endfunction

    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom); while (is_skip(c));
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] data_char();
        logic [CHAR_W-1:0] c;
        do c = ($urandom_range(0, 4) == 0) ? CHAR_W'($urandom) : hex_char();
        while (c == close_ch);
        return c;
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_char <= c;
        do @(posedge i_clk); while (!(rx_ch.valid && rx_ch.ready));
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k]);
        end
    endtask

    // occasional whitespace, legal in every phase
    task automatic noise();
        case ($urandom_range(0, 9))
            0: send_char(CH_SPACE);
            1: send_char(CH_LF);
            2: send_char(CH_CR);
            default: begin
            end
        endcase
    endtask

    task automatic send_packet(input logic [CHAR_W-1:0] rw, input int digits);
        send_char(open_ch);
        send_char(rw);
        repeat (4) begin
            noise();
            send_char(($urandom_range(0, 4) == 0) ? plain_char() : hex_char());
        end
        repeat (digits) begin
            noise();
            send_char(data_char());
        end
        send_char(close_ch);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CHAR_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_START_CHAR) begin
            open_ch = value;
        end else begin
            close_ch = value;
        end
    endtask

    // parser back in idle with nothing in flight
    task automatic settle();
        rx_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (WRITE_SETTLE) @(negedge i_clk);
    endtask

    initial begin
        int stall;
        int taken;
        taken        = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (taken % 16 == 0) begin
                stall_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
            end
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            @(negedge i_clk);
            taken++;
        end
    end

    initial begin
        int                pkt;
        int                digits;
        int                waited;
        logic [CHAR_W-1:0] rw;
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_char <= '0;
        gap_max    = 8;
        items_sent = 0;
        open_ch    = START_CHAR_RST;
        close_ch   = END_CHAR_RST;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(REG_START_CHAR, START_CHAR_RST);
        write_reg(REG_END_CHAR, END_CHAR_RST);
        // whitespace, lowercase digit and an odd trailing nibble
        send_text("S\nW0FA5 1a 7\rP");
        // empty write, end character used as an address digit
        send_text("SWPF00P");
        send_text("SR0000P");

        pkt = 0;
        while (items_sent < ITEM_TARGET) begin
            if (pkt % 6 == 5) begin
                settle();
                case (pkt / 6)
                    0: begin
                        write_reg(REG_START_CHAR, 8'h00);
                        write_reg(REG_END_CHAR, 8'hFF);
                    end
                    1: begin
                        write_reg(REG_START_CHAR, 8'hFF);
                        write_reg(REG_END_CHAR, 8'h00);
                    end
                    default: begin
                        write_reg(REG_START_CHAR, plain_char());
                        write_reg(REG_END_CHAR, plain_char());
                    end
                endcase
            end
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            noise();
            rw = ($urandom_range(0, 3) == 0) ? plain_char() : CH_WRITE;
            if (pkt % 9 == 2 || $urandom_range(0, 14) == 0) begin
                digits = $urandom_range(66, 70);
            end else begin
                digits = $urandom_range(0, 14);
            end
            send_packet(rw, digits);
            pkt++;
        end

        // start character that is itself skipped, then a bad opener
        settle();
        gap_max = 8;
        write_reg(REG_START_CHAR, CH_SPACE);
        send_char(CH_SPACE);
        send_char(CH_LF);
        send_char(CH_WRITE);
        repeat (3) send_char(plain_char());
        rx_ch.valid <= 1'b0;

        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (40) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### ascii_hex_packet_parser_core.f
rtl/ahpp_pkg.sv
rtl/ahpp_if.sv
rtl/ahpp_ctrl.sv
rtl/ahpp_dp.sv
rtl/ascii_hex_packet_parser_core.sv
verif/ahpp_packet_checker.sv
verif/tb_ascii_hex_packet_parser_core.sv
